// File: rtl/lobbp_pkg.sv
// ----------------------------------------------------------------------------
// lobbp_pkg
// Shared types and codes of the order book best price core.
// ----------------------------------------------------------------------------
`default_nettype none

package lobbp_pkg;

    // item modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    // one table entry
    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] ident;
        logic [31:0] seq;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/limit_order_book_best_price_core.sv
// ----------------------------------------------------------------------------
// limit_order_book_best_price_core
// Bounded limit order book: add, cancel or flush, then best bid and ask.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  input    in         i_valid / o_stall     mode, side, order_price, order_id
//  output   out        o_valid / i_stall     status, bid/ask valid, price, id
//
//  One item at a time. Each sweep reads the entry memory once per entry.
//  Add and cancel miss run a find sweep and a best price sweep. A cancel
//  hit adds a victim sweep between them. Flush and unused mode run only
//  the best price sweep. An output stall holds the result until it is taken.
//  Used and latest flags are flip-flops cleared by reset; entry data needs no
//  clearing. The input stalls while an item is at work or its result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_best_price_core
    import lobbp_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_mode,
    input  wire logic               i_side,
    input  wire logic [31:0]        i_order_price,
    input  wire logic signed [31:0] i_order_id,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic                    o_bid_valid,
    output logic [31:0]             o_bid_price,
    output logic signed [31:0]      o_bid_order_id,
    output logic                    o_ask_valid,
    output logic [31:0]             o_ask_price,
    output logic signed [31:0]      o_ask_order_id
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIND = 3'd1;   // sweep for free slot / latest
    localparam logic [2:0] ST_VIC  = 3'd2;   // cancel victim sweep
    localparam logic [2:0] ST_BEST = 3'd3;   // best price sweep
    localparam logic [2:0] ST_OUT  = 3'd4;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    logic   r_rd_ok;
    logic [AW-1:0] r_rd_idx;

    logic [TABLE_DEPTH-1:0] r_used, r_latest;
    logic [2:0]  r_state;
    logic [CW-1:0] r_cnt;
    logic [1:0]  r_mode;
    logic        r_side;
    logic [31:0] r_price, r_id, r_arrival;
    logic [1:0]  r_status;
    // find results
    logic        r_free_ok, r_lat_ok;
    logic [AW-1:0] r_free_idx, r_lat_idx;
    logic        r_lat_side;
    logic [31:0] r_lat_price;
    logic        r_vic_ok;
    logic [AW-1:0] r_vic_idx;
    logic [31:0] r_vic_seq;
    // best tracking
    logic        r_bv, r_av;
    logic [31:0] r_bp, r_bi, r_bs, r_ap, r_ai, r_as;
    logic        r_oval;

    logic        in_acc, wr_en;
    logic [AW-1:0] wr_idx, rd_idx;
    t_entry      wr_data;
    logic        sweep_last;
    // search results including the entry returning this cycle
    logic        free_now, vic_hit, vic_now;
    logic [AW-1:0] free_idx_now, vic_idx_now;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || !i_rst_n;
    assign rd_idx = r_cnt[AW-1:0];
    assign sweep_last = (r_cnt == CW'(TABLE_DEPTH - 1));

    assign free_now     = r_free_ok || !r_used[r_rd_idx];
    assign free_idx_now = r_free_ok ? r_free_idx : r_rd_idx;
    assign vic_hit      = r_used[r_rd_idx] && r_rd.ident == r_id
                          && r_rd.side == r_lat_side && r_rd.price == r_lat_price
                          && (!r_vic_ok || r_rd.seq < r_vic_seq);
    assign vic_now      = r_vic_ok || vic_hit;
    assign vic_idx_now  = vic_hit ? r_rd_idx : r_vic_idx;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_rd <= r_mem[rd_idx];
        r_rd_idx <= rd_idx;
    end

    // write of a new entry at the end of the add find sweep
    always_comb begin
        wr_en   = (r_state == ST_FIND) && r_rd_ok && (r_rd_idx == AW'(TABLE_DEPTH - 1))
                  && (r_mode == MODE_ADD) && free_now;
        wr_idx  = free_idx_now;
        wr_data = '{side: r_side, price: r_price, ident: r_id, seq: r_arrival};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_latest <= '0;
            r_arrival <= '0;
            r_oval   <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_ok <= 1'b0;
                    r_cnt   <= '0;
                    if (in_acc) begin
                        r_mode <= i_mode; r_side <= i_side;
                        r_price <= i_order_price; r_id <= i_order_id;
                        r_status <= STAT_OK;
                        r_free_ok <= 1'b0; r_lat_ok <= 1'b0; r_vic_ok <= 1'b0;
                        r_bv <= 1'b0; r_av <= 1'b0;
                        if (i_mode == MODE_FLUSH) begin
                            r_used <= '0; r_latest <= '0; r_arrival <= '0;
                            r_state <= ST_BEST;
                        end else if (i_mode == MODE_ADD || i_mode == MODE_CANCEL) begin
                            r_state <= ST_FIND;
                        end else begin
                            r_state <= ST_BEST;
                        end
                    end
                end
                ST_FIND, ST_VIC, ST_BEST: begin
                    // issue reads, then look at returning data
                    if (!sweep_last) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_rd_ok <= !(r_rd_ok && r_rd_idx == AW'(TABLE_DEPTH - 1));
                    if (r_rd_ok) begin
                        if (r_state == ST_FIND) begin
                            if (!r_used[r_rd_idx] && !r_free_ok) begin
                                r_free_ok <= 1'b1; r_free_idx <= r_rd_idx;
                            end
                            if (r_used[r_rd_idx] && r_latest[r_rd_idx]
                                && r_rd.ident == r_id && !r_lat_ok) begin
                                r_lat_ok <= 1'b1; r_lat_idx <= r_rd_idx;
                                r_lat_side <= r_rd.side; r_lat_price <= r_rd.price;
                            end
                        end else if (r_state == ST_VIC) begin
                            if (vic_hit) begin
                                r_vic_ok <= 1'b1; r_vic_idx <= r_rd_idx;
                                r_vic_seq <= r_rd.seq;
                            end
                        end else if (r_used[r_rd_idx]) begin
                            if (!r_rd.side) begin
                                if (!r_bv || r_rd.price > r_bp
                                    || (r_rd.price == r_bp && r_rd.seq > r_bs)) begin
                                    r_bv <= 1'b1; r_bp <= r_rd.price;
                                    r_bi <= r_rd.ident; r_bs <= r_rd.seq;
                                end
                            end else if (!r_av || r_rd.price < r_ap
                                         || (r_rd.price == r_ap && r_rd.seq < r_as)) begin
                                r_av <= 1'b1; r_ap <= r_rd.price;
                                r_ai <= r_rd.ident; r_as <= r_rd.seq;
                            end
                        end
                        // end of sweep
                        if (r_rd_idx == AW'(TABLE_DEPTH - 1)) begin
                            r_cnt <= '0;
                            if (r_state == ST_FIND && r_mode == MODE_ADD) begin
                                if (free_now) begin
                                    r_used[free_idx_now] <= 1'b1;
                                    r_arrival <= r_arrival + 32'd1;
                                    // latest flag moves to the new slot
                                    r_latest[free_idx_now] <= 1'b1;
                                    if (r_lat_ok) begin
                                        r_latest[r_lat_idx] <= 1'b0;
                                    end
                                    if (r_used[r_rd_idx] && r_latest[r_rd_idx]
                                        && r_rd.ident == r_id && !r_lat_ok) begin
                                        r_latest[r_rd_idx] <= 1'b0;
                                    end
                                end else begin
                                    r_status <= STAT_FULL;
                                end
                                r_state <= ST_BEST;
                            end else if (r_state == ST_FIND) begin
                                if (r_lat_ok || (r_used[r_rd_idx] && r_latest[r_rd_idx]
                                                 && r_rd.ident == r_id)) begin
                                    r_state <= ST_VIC;
                                end else begin
                                    r_status <= STAT_NOTFOUND;
                                    r_state <= ST_BEST;
                                end
                            end else if (r_state == ST_VIC) begin
                                r_latest[r_lat_idx] <= 1'b0;
                                if (vic_now) begin
                                    r_used[vic_idx_now] <= 1'b0;
                                    r_latest[vic_idx_now] <= 1'b0;
                                end
                                r_state <= ST_BEST;
                            end else begin
                                r_state <= ST_OUT;
                                r_oval <= 1'b1;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_oval <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_oval;
    assign o_status       = r_status;
    assign o_bid_valid    = r_bv;
    assign o_bid_price    = r_bv ? r_bp : 32'd0;
    assign o_bid_order_id = r_bv ? r_bi : 32'd0;
    assign o_ask_valid    = r_av;
    assign o_ask_price    = r_av ? r_ap : 32'd0;
    assign o_ask_order_id = r_av ? r_ai : 32'd0;

endmodule

`default_nettype wire
